@@ rtl/disk_block_availability_map_unit_defines.svh @@
// Assertion macros shared by the block availability map design.
`ifndef DISK_BLOCK_AVAILABILITY_MAP_UNIT_DEFINES_SVH
`define DISK_BLOCK_AVAILABILITY_MAP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DBAM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DBAM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DBAM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DBAM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/dbam_pkg.sv @@
// Types, constants and helper functions of the block availability map.
package dbam_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned TRACK_W  = 6;
  localparam int unsigned SECTOR_W = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BITS_W   = 21;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned BLK_W    = 10;

  localparam logic [TRACK_W-1:0] DIR_TRACK     = TRACK_W'(18);
  localparam logic [TRACK_W-1:0] LOW_SCAN_TOP  = TRACK_W'(17);
  localparam logic [TRACK_W-1:0] HIGH_SCAN_OFS = TRACK_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_FIND   = 3'd2,
    OP_COUNT  = 3'd3,
    OP_FORMAT = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_ILLEGAL      = 3'd1,
    ST_IN_USE       = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_FULL         = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_ITEM,
    SEL_HIT,
    SEL_COUNT
  } res_sel_e;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [BITS_W-1:0] bits;
  } entry_t;

  typedef struct packed {
    logic               load_item;
    logic               rd_en;
    logic               rd_item;
    logic [TRACK_W-1:0] rd_track;
    logic               wr_en;
    logic               wr_free;
    logic               clr_map;
    logic               acc_clr;
    logic               acc_add;
    logic               ld_res;
    status_e            res_status;
    res_sel_e           res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            in_legal;
    logic            is_free;
    logic            hit;
    logic            rd_live;
  } dp_status_t;

  function automatic logic [SECTOR_W-1:0] zone_sectors(input logic [TRACK_W-1:0] trk);
    logic [SECTOR_W-1:0] n;
    if (trk < TRACK_W'(18)) begin
      n = SECTOR_W'(21);
    end else if (trk < TRACK_W'(25)) begin
      n = SECTOR_W'(19);
    end else if (trk < TRACK_W'(31)) begin
      n = SECTOR_W'(18);
    end else begin
      n = SECTOR_W'(17);
    end
    return n;
  endfunction

  function automatic entry_t reset_entry(input logic [TRACK_W-1:0] trk);
    logic [SECTOR_W-1:0] n;
    logic [BITS_W:0]     full;
    entry_t              e;
    n      = zone_sectors(trk);
    full   = ((BITS_W + 1)'(1) << n) - (BITS_W + 1)'(1);
    e.bits = full[BITS_W-1:0];
    e.cnt  = CNT_W'(n);
    if (trk == DIR_TRACK) begin
      e.bits[0] = 1'b0;
      e.cnt     = e.cnt - CNT_W'(1);
    end
    return e;
  endfunction

  function automatic logic [SECTOR_W-1:0] first_set(input logic [BITS_W-1:0] bits);
    logic [SECTOR_W-1:0] idx;
    idx = '0;
    for (int i = BITS_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = SECTOR_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/dbam_datapath.sv @@
// Datapath: item registers, track map memory, scan check, counter and result registers.
module dbam_datapath import dbam_pkg::*; #(
  parameter int unsigned NUM_TRACKS = 35
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [OP_W-1:0]     op_i,
  input  logic [TRACK_W-1:0]  track_i,
  input  logic [SECTOR_W-1:0] sector_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          st_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [TRACK_W-1:0]  found_track_o,
  output logic [SECTOR_W-1:0] found_sector_o,
  output logic [BLK_W-1:0]    free_blocks_o
);

  localparam int unsigned IDX_W = $clog2(NUM_TRACKS);

  logic [TRACK_W-1:0]  track_q;
  logic [SECTOR_W-1:0] sector_q;

  entry_t              mem [NUM_TRACKS];
  logic [NUM_TRACKS-1:0] valid_q;

  entry_t              rd_data_q;
  logic                rd_valid_q;
  logic [TRACK_W-1:0]  rd_track_q;
  logic                rd_live_q;

  logic [BLK_W-1:0]    acc_q;

  logic [STATUS_W-1:0] status_q;
  logic [TRACK_W-1:0]  ftrk_q;
  logic [SECTOR_W-1:0] fsec_q;
  logic [BLK_W-1:0]    blocks_q;

  logic [TRACK_W-1:0]  rd_trk;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              eff;
  entry_t              wr_data;
  logic [BITS_W-1:0]   mask;

  assign rd_trk  = cmd_i.rd_item ? track_q : cmd_i.rd_track;
  assign rd_addr = IDX_W'(rd_trk - TRACK_W'(1));
  assign wr_addr = IDX_W'(track_q - TRACK_W'(1));
  assign eff     = rd_valid_q ? rd_data_q : reset_entry(rd_track_q);
  assign mask    = BITS_W'(1) << sector_q;

  always_comb begin
    wr_data = eff;
    if (cmd_i.wr_free) begin
      wr_data.bits = eff.bits | mask;
      wr_data.cnt  = eff.cnt + CNT_W'(1);
    end else begin
      wr_data.bits = eff.bits & ~mask;
      wr_data.cnt  = eff.cnt - CNT_W'(1);
    end
  end

  assign st_o.in_op    = op_i;
  assign st_o.in_legal = (track_i != '0) && (track_i <= TRACK_W'(NUM_TRACKS)) &&
                         (sector_i < zone_sectors(track_i));
  assign st_o.is_free  = |(eff.bits & mask);
  assign st_o.hit      = rd_live_q && (|eff.bits);
  assign st_o.rd_live  = rd_live_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      track_q  <= track_i;
      sector_q <= sector_i;
    end
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q  <= mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
      rd_track_q <= rd_trk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_live_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      rd_live_q <= cmd_i.rd_en;
      if (cmd_i.clr_map) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (cmd_i.acc_add && rd_live_q && (rd_track_q != DIR_TRACK)) begin
        acc_q <= acc_q + BLK_W'(eff.cnt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_res) begin
      status_q <= cmd_i.res_status;
      case (cmd_i.res_sel)
        SEL_ITEM: begin
          ftrk_q   <= track_q;
          fsec_q   <= sector_q;
          blocks_q <= '0;
        end
        SEL_HIT: begin
          ftrk_q   <= rd_track_q;
          fsec_q   <= first_set(eff.bits);
          blocks_q <= '0;
        end
        SEL_COUNT: begin
          ftrk_q   <= '0;
          fsec_q   <= '0;
          blocks_q <= acc_q;
        end
        default: begin
          ftrk_q   <= '0;
          fsec_q   <= '0;
          blocks_q <= '0;
        end
      endcase
    end
  end

  assign status_o       = status_q;
  assign found_track_o  = ftrk_q;
  assign found_sector_o = fsec_q;
  assign free_blocks_o  = blocks_q;

endmodule

@@ rtl/dbam_ctrl.sv @@
// Controller state machine that sequences lookups, scans and result delivery.
module dbam_ctrl import dbam_pkg::*; #(
  parameter int unsigned NUM_TRACKS = 35
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_stall_i,
  input  dp_status_t st_i,
  output dp_cmd_t    cmd_o,
  output logic       in_stall_o,
  output logic       out_valid_o
);

  localparam int unsigned K_W = $clog2(NUM_TRACKS + 1);
  localparam logic [K_W-1:0] SCAN_LEN  = K_W'(NUM_TRACKS - 1);
  localparam logic [K_W-1:0] COUNT_LEN = K_W'(NUM_TRACKS);
  localparam logic [K_W-1:0] LOW_LEN   = K_W'(17);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_SCAN,
    S_COUNT,
    S_RESULT
  } state_e;

  state_e   state_q, state_d;
  logic [K_W-1:0] k_q, k_d;
  logic     is_alloc_q, is_alloc_d;
  status_e  hit_code_q, hit_code_d;
  status_e  res_status_q, res_status_d;
  res_sel_e res_sel_q, res_sel_d;
  logic     out_valid_q, out_valid_d;

  logic     accept;
  logic     out_free;
  logic [TRACK_W-1:0] scan_trk;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign scan_trk = (k_q < LOW_LEN) ? (LOW_SCAN_TOP - TRACK_W'(k_q))
                                    : (TRACK_W'(k_q) + HIGH_SCAN_OFS);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    is_alloc_d   = is_alloc_q;
    hit_code_d   = hit_code_q;
    res_status_d = res_status_q;
    res_sel_d    = res_sel_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cmd_o            = '0;
    cmd_o.res_status = res_status_q;
    cmd_o.res_sel    = res_sel_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          k_d             = '0;
          res_status_d    = ST_OK;
          res_sel_d       = SEL_NONE;
          state_d         = S_RESULT;
          unique case (st_i.in_op)
            OP_ALLOC, OP_FREE: begin
              is_alloc_d = (st_i.in_op == OP_ALLOC);
              if (st_i.in_legal) begin
                state_d = S_LOOKUP;
              end else begin
                res_status_d = ST_ILLEGAL;
                res_sel_d    = SEL_ITEM;
              end
            end
            OP_FIND: begin
              hit_code_d = ST_OK;
              state_d    = S_SCAN;
            end
            OP_COUNT: begin
              cmd_o.acc_clr = 1'b1;
              state_d       = S_COUNT;
            end
            OP_FORMAT: begin
              cmd_o.clr_map = 1'b1;
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_item = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_RESULT;
        if (is_alloc_q) begin
          if (st_i.is_free) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            hit_code_d = ST_IN_USE;
            state_d    = S_SCAN;
          end
        end else if (st_i.is_free) begin
          res_status_d = ST_ALREADY_FREE;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_free = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.rd_track = scan_trk;
        if (st_i.hit) begin
          res_status_d = hit_code_q;
          res_sel_d    = SEL_HIT;
          state_d      = S_RESULT;
        end else if (k_q < SCAN_LEN) begin
          cmd_o.rd_en = 1'b1;
          k_d         = k_q + K_W'(1);
        end else if (!st_i.rd_live) begin
          res_status_d = ST_FULL;
          res_sel_d    = SEL_NONE;
          state_d      = S_RESULT;
        end
      end
      S_COUNT: begin
        cmd_o.rd_track = TRACK_W'(k_q) + TRACK_W'(1);
        cmd_o.acc_add  = 1'b1;
        if (k_q < COUNT_LEN) begin
          cmd_o.rd_en = 1'b1;
          k_d         = k_q + K_W'(1);
        end else if (!st_i.rd_live) begin
          res_sel_d = SEL_COUNT;
          state_d   = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.ld_res = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= '0;
      is_alloc_q   <= 1'b0;
      hit_code_q   <= ST_OK;
      res_status_q <= ST_OK;
      res_sel_q    <= SEL_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      is_alloc_q   <= is_alloc_d;
      hit_code_q   <= hit_code_d;
      res_status_q <= res_status_d;
      res_sel_q    <= res_sel_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/disk_block_availability_map_unit.sv @@
// Top level of the disk block availability map unit.
// The unit handles one transaction at a time and holds the finished result in an
// output register, so it takes the next transaction while that result waits.
// The track map lives in a memory with one read port and a registered read, and
// each track carries a flag that makes an unwritten entry read as its formatted
// value; reset and format therefore take effect at once with no clearing pass.
// Format, an unknown op or an illegal block go straight to the result; free and
// allocate read and check the item's track first; find free, allocate of a used
// block and count free walk the map one track per cycle through the read port
// and drain the last read.
// The next transaction can be accepted in the cycle after the result is loaded.
`include "disk_block_availability_map_unit_defines.svh"

module disk_block_availability_map_unit import dbam_pkg::*; #(
  parameter int unsigned NUM_TRACKS = 35
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [TRACK_W-1:0]  track_i,
  input  logic [SECTOR_W-1:0] sector_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [TRACK_W-1:0]  found_track_o,
  output logic [SECTOR_W-1:0] found_sector_o,
  output logic [BLK_W-1:0]    free_blocks_o
);

  dp_cmd_t    cmd;
  dp_status_t st;

  dbam_ctrl #(
    .NUM_TRACKS(NUM_TRACKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  dbam_datapath #(
    .NUM_TRACKS(NUM_TRACKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .track_i       (track_i),
    .sector_i      (sector_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .status_o      (status_o),
    .found_track_o (found_track_o),
    .found_sector_o(found_sector_o),
    .free_blocks_o (free_blocks_o)
  );

  `DBAM_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "unit took a transaction without going busy")
  `DBAM_ASSERT_IMP(a_blocks_only_ok, clk_i, rst_ni, out_valid_o && (free_blocks_o != '0), status_o == ST_OK, "free block count with a non-ok status")
  `DBAM_ASSERT_IMP(a_full_has_no_block, clk_i, rst_ni, out_valid_o && (status_o == ST_FULL), (found_track_o == '0) && (found_sector_o == '0), "disk full result names a block")
  `DBAM_ASSERT_IMP(a_no_dir_track_found, clk_i, rst_ni, out_valid_o && ((status_o == ST_OK) || (status_o == ST_IN_USE)), found_track_o != DIR_TRACK, "scan nominated the directory track")

endmodule
